/* hdl/sdf_pkg.sv */
package sdf_pkg;

   localparam int FRAC_BITS = 16;

   localparam int XW   = 32;
   localparam int KW   = 32;
   localparam int LW   = 31;
   localparam int PDW  = 32;
   localparam int AW   = 4;

   localparam int DW   = XW + 1;
   localparam int SQW  = 2 * DW;
   localparam int NW   = SQW + 2;
   localparam int L2W  = 2 * LW;
   localparam int RW   = (NW + 1) / 2;
   localparam int RADW = 2 * RW;
   localparam int REMW = RW + 3;
   localparam int QW   = FRAC_BITS + 1;
   localparam int DRW  = RW + 1;
   localparam int UW   = QW + 1;
   localparam int PRW  = DW + UW;
   localparam int PW   = PRW + 2;
   localparam int KSW  = KW + RW;
   localparam int KSL  = KSW / 2;
   localparam int KSH  = KSW - KSL;
   localparam int FW   = KSW + QW;
   localparam int FSW  = FW - 2 * FRAC_BITS;
   localparam int PML  = PW / 2;
   localparam int PMH  = PW - PML;
   localparam int BPW  = KW + PW;
   localparam int BC   = (BPW + 2) / 3;
   localparam int BCT  = BPW - 2 * BC;
   localparam int GW   = BPW + QW;
   localparam int GSW  = GW - 3 * FRAC_BITS;
   localparam int SATW = (FSW > GSW) ? FSW : GSW;

   localparam logic [KW-1:0] SPRING_CONSTANT_RESET = KW'(1) << FRAC_BITS;

   typedef enum logic [AW-3:0] {
      REG_SPRING_CONSTANT,
      REG_REST_LENGTH,
      REG_DAMPING_COEFFICIENT
   } reg_index_type;

   typedef struct packed {
      logic signed [XW-1:0] proxy_x;
      logic signed [XW-1:0] proxy_y;
      logic signed [XW-1:0] proxy_z;
      logic signed [XW-1:0] anchor_x;
      logic signed [XW-1:0] anchor_y;
      logic signed [XW-1:0] anchor_z;
      logic signed [XW-1:0] vel_a_x;
      logic signed [XW-1:0] vel_a_y;
      logic signed [XW-1:0] vel_a_z;
      logic signed [XW-1:0] vel_b_x;
      logic signed [XW-1:0] vel_b_y;
      logic signed [XW-1:0] vel_b_z;
   } req_type;

   typedef struct packed {
      logic signed [XW-1:0] spring_fx;
      logic signed [XW-1:0] spring_fy;
      logic signed [XW-1:0] spring_fz;
      logic signed [XW-1:0] damp_a_x;
      logic signed [XW-1:0] damp_a_y;
      logic signed [XW-1:0] damp_a_z;
      logic signed [XW-1:0] damp_b_x;
      logic signed [XW-1:0] damp_b_y;
      logic signed [XW-1:0] damp_b_z;
      logic                 stretched;
   } rsp_type;

   typedef struct packed {
      logic [KW-1:0] spring_constant;
      logic [LW-1:0] rest_length;
      logic [KW-1:0] damping_coefficient;
   } cfg_type;

   typedef struct packed {
      logic                 stretched;
      logic [2:0]           neg;
      logic [2:0][DW-1:0]   mag;
      logic [2:0][DW-1:0]   vsum;
   } side_type;

   typedef struct packed {
      logic            valid;
      side_type        side;
      logic [RADW-1:0] rad;
      logic [REMW-1:0] rem;
      logic [RW-1:0]   root;
   } sqst_type;

   typedef struct packed {
      logic                valid;
      side_type            side;
      logic [RW-1:0]       d;
      logic [2:0][DRW-1:0] r;
      logic [2:0][QW-1:0]  q;
   } divst_type;

   typedef struct packed {
      logic               valid;
      logic               stretched;
      logic [2:0]         neg;
      logic [2:0][QW-1:0] um;
   } tail_type;

endpackage

/* hdl/sdf_datapath.sv */
module sdf_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  sdf_pkg::req_type in_data,
   input  sdf_pkg::cfg_type cfg,
   output logic             out_valid,
   output sdf_pkg::rsp_type out_data
);

   function automatic sdf_pkg::sqst_type sqrt_step(sdf_pkg::sqst_type s);
      sdf_pkg::sqst_type r;
      logic [sdf_pkg::REMW-1:0] rem;
      logic [sdf_pkg::REMW-1:0] trial;
      r = s;
      rem = {s.rem[sdf_pkg::REMW-3:0], s.rad[sdf_pkg::RADW-1 -: 2]};
      trial = sdf_pkg::REMW'({s.root, 2'b01});
      r.rad = s.rad << 2;
      if (rem >= trial) begin
         r.rem = rem - trial;
         r.root = {s.root[sdf_pkg::RW-2:0], 1'b1};
      end else begin
         r.rem = rem;
         r.root = {s.root[sdf_pkg::RW-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic sdf_pkg::divst_type div_step(sdf_pkg::divst_type s, logic first);
      sdf_pkg::divst_type r;
      logic [sdf_pkg::DRW-1:0] t;
      r = s;
      for (int l = 0; l < 3; l++) begin
         t = first ? s.r[l] : {s.r[l][sdf_pkg::DRW-2:0], 1'b0};
         if (t >= sdf_pkg::DRW'(s.d)) begin
            r.r[l] = t - sdf_pkg::DRW'(s.d);
            r.q[l] = {s.q[l][sdf_pkg::QW-2:0], 1'b1};
         end else begin
            r.r[l] = t;
            r.q[l] = {s.q[l][sdf_pkg::QW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic logic [sdf_pkg::XW-1:0] sat_out(logic [sdf_pkg::SATW-1:0] mag,
                                                       logic neg);
      logic [sdf_pkg::SATW-1:0] lim;
      logic [sdf_pkg::XW-1:0]   m;
      lim = sdf_pkg::SATW'(neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
      m = (mag > lim) ? lim[sdf_pkg::XW-1:0] : mag[sdf_pkg::XW-1:0];
      return neg ? -m : m;
   endfunction

   // stage 0: differences and velocity sums
   logic                               s0_v_ff;
   logic [2:0][sdf_pkg::DW-1:0]        s0_dv_ff, s0_dv_in;
   logic [2:0][sdf_pkg::DW-1:0]        s0_vs_ff, s0_vs_in;

   always_comb begin
      s0_dv_in[0] = sdf_pkg::DW'(in_data.proxy_x) - sdf_pkg::DW'(in_data.anchor_x);
      s0_dv_in[1] = sdf_pkg::DW'(in_data.proxy_y) - sdf_pkg::DW'(in_data.anchor_y);
      s0_dv_in[2] = sdf_pkg::DW'(in_data.proxy_z) - sdf_pkg::DW'(in_data.anchor_z);
      s0_vs_in[0] = sdf_pkg::DW'(in_data.vel_a_x) + sdf_pkg::DW'(in_data.vel_b_x);
      s0_vs_in[1] = sdf_pkg::DW'(in_data.vel_a_y) + sdf_pkg::DW'(in_data.vel_b_y);
      s0_vs_in[2] = sdf_pkg::DW'(in_data.vel_a_z) + sdf_pkg::DW'(in_data.vel_b_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= in_valid;
      end
      if (en) begin
         s0_dv_ff <= s0_dv_in;
         s0_vs_ff <= s0_vs_in;
      end
   end

   // stage 1: magnitudes and squares
   logic                               s1_v_ff;
   sdf_pkg::side_type                  s1_side_ff, s1_side_in;
   logic [2:0][sdf_pkg::SQW-1:0]       s1_sq_ff, s1_sq_in;
   logic [sdf_pkg::L2W-1:0]            s1_l2_ff, s1_l2_in;

   always_comb begin
      s1_side_in = '0;
      s1_side_in.vsum = s0_vs_ff;
      for (int l = 0; l < 3; l++) begin
         s1_side_in.neg[l] = s0_dv_ff[l][sdf_pkg::DW-1];
         s1_side_in.mag[l] = s0_dv_ff[l][sdf_pkg::DW-1] ? -s0_dv_ff[l] : s0_dv_ff[l];
         s1_sq_in[l] = sdf_pkg::SQW'(s1_side_in.mag[l]) * sdf_pkg::SQW'(s1_side_in.mag[l]);
      end
      s1_l2_in = sdf_pkg::L2W'(cfg.rest_length) * sdf_pkg::L2W'(cfg.rest_length);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= s0_v_ff;
      end
      if (en) begin
         s1_side_ff <= s1_side_in;
         s1_sq_ff <= s1_sq_in;
         s1_l2_ff <= s1_l2_in;
      end
   end

   // stage 2: squared distance and stretch test
   sdf_pkg::sqst_type start_ff, start_in;
   logic [sdf_pkg::NW-1:0] n_sum;

   always_comb begin
      n_sum = sdf_pkg::NW'(s1_sq_ff[0]) + sdf_pkg::NW'(s1_sq_ff[1]) +
              sdf_pkg::NW'(s1_sq_ff[2]);
      start_in = '0;
      start_in.valid = s1_v_ff;
      start_in.side = s1_side_ff;
      start_in.side.stretched = n_sum > sdf_pkg::NW'(s1_l2_ff);
      start_in.rad = sdf_pkg::RADW'(n_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff.valid <= 1'b0;
      end else if (en) begin
         start_ff <= start_in;
      end
   end

   // square root, one result bit per stage
   sdf_pkg::sqst_type sq_ff  [sdf_pkg::RW];
   sdf_pkg::sqst_type sq_in  [sdf_pkg::RW];
   sdf_pkg::sqst_type sq_cur [sdf_pkg::RW+1];

   assign sq_cur[0] = start_ff;

   for (genvar i = 0; i < sdf_pkg::RW; i++) begin : g_sqrt
      assign sq_in[i] = sqrt_step(sq_cur[i]);
      assign sq_cur[i+1] = sq_ff[i];
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[i].valid <= 1'b0;
         end else if (en) begin
            sq_ff[i] <= sq_in[i];
         end
      end
   end

   // direction: restoring divide, one quotient bit per stage
   sdf_pkg::divst_type dv_ff  [sdf_pkg::QW];
   sdf_pkg::divst_type dv_in  [sdf_pkg::QW];
   sdf_pkg::divst_type dv_cur [sdf_pkg::QW+1];

   always_comb begin
      dv_cur[0] = '0;
      dv_cur[0].valid = sq_cur[sdf_pkg::RW].valid;
      dv_cur[0].side = sq_cur[sdf_pkg::RW].side;
      dv_cur[0].d = sq_cur[sdf_pkg::RW].root;
      for (int l = 0; l < 3; l++) begin
         dv_cur[0].r[l] = sdf_pkg::DRW'(sq_cur[sdf_pkg::RW].side.mag[l]);
      end
   end

   for (genvar j = 0; j < sdf_pkg::QW; j++) begin : g_div
      assign dv_in[j] = div_step(dv_cur[j], 1'(j == 0));
      assign dv_cur[j+1] = dv_ff[j];
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j].valid <= 1'b0;
         end else if (en) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // M1: projection products, k*(d-L)
   sdf_pkg::tail_type                  m1_t_ff, m1_t_in;
   logic [2:0][sdf_pkg::PRW-1:0]       m1_prod_ff, m1_prod_in;
   logic [sdf_pkg::KSW-1:0]            m1_ks_ff, m1_ks_in;
   logic [sdf_pkg::UW-1:0]             us;
   logic [sdf_pkg::RW-1:0]             stretch_len;

   always_comb begin
      m1_t_in.valid = dv_cur[sdf_pkg::QW].valid;
      m1_t_in.stretched = dv_cur[sdf_pkg::QW].side.stretched;
      m1_t_in.neg = dv_cur[sdf_pkg::QW].side.neg;
      m1_t_in.um = dv_cur[sdf_pkg::QW].q;
      us = '0;
      for (int l = 0; l < 3; l++) begin
         us = dv_cur[sdf_pkg::QW].side.neg[l] ? -sdf_pkg::UW'(dv_cur[sdf_pkg::QW].q[l])
                                              : sdf_pkg::UW'(dv_cur[sdf_pkg::QW].q[l]);
         m1_prod_in[l] = sdf_pkg::PRW'($signed(dv_cur[sdf_pkg::QW].side.vsum[l])) *
                         sdf_pkg::PRW'($signed(us));
      end
      stretch_len = dv_cur[sdf_pkg::QW].d - sdf_pkg::RW'(cfg.rest_length);
      m1_ks_in = sdf_pkg::KSW'(cfg.spring_constant) * sdf_pkg::KSW'(stretch_len);
   end

   // M2: projection sum, spring partial products
   sdf_pkg::tail_type                           m2_t_ff;
   logic [sdf_pkg::PW-1:0]                      m2_p_ff, m2_p_in;
   logic [2:0][sdf_pkg::KSL+sdf_pkg::QW-1:0]    m2_fl_ff, m2_fl_in;
   logic [2:0][sdf_pkg::KSH+sdf_pkg::QW-1:0]    m2_fh_ff, m2_fh_in;

   always_comb begin
      m2_p_in = sdf_pkg::PW'($signed(m1_prod_ff[0])) + sdf_pkg::PW'($signed(m1_prod_ff[1])) +
                sdf_pkg::PW'($signed(m1_prod_ff[2]));
      for (int l = 0; l < 3; l++) begin
         m2_fl_in[l] = (sdf_pkg::KSL+sdf_pkg::QW)'(m1_ks_ff[sdf_pkg::KSL-1:0]) *
                       (sdf_pkg::KSL+sdf_pkg::QW)'(m1_t_ff.um[l]);
         m2_fh_in[l] = (sdf_pkg::KSH+sdf_pkg::QW)'(m1_ks_ff[sdf_pkg::KSW-1:sdf_pkg::KSL]) *
                       (sdf_pkg::KSH+sdf_pkg::QW)'(m1_t_ff.um[l]);
      end
   end

   // M3: |p|, spring magnitude
   sdf_pkg::tail_type                  m3_t_ff;
   logic                               m3_pneg_ff, m3_pneg_in;
   logic [sdf_pkg::PW-1:0]             m3_pm_ff, m3_pm_in;
   logic [2:0][sdf_pkg::FSW-1:0]       m3_fs_ff, m3_fs_in;
   logic [sdf_pkg::FW-1:0]             f_full;

   always_comb begin
      m3_pneg_in = m2_p_ff[sdf_pkg::PW-1];
      m3_pm_in = m3_pneg_in ? -m2_p_ff : m2_p_ff;
      f_full = '0;
      for (int l = 0; l < 3; l++) begin
         f_full = sdf_pkg::FW'(m2_fl_ff[l]) + (sdf_pkg::FW'(m2_fh_ff[l]) << sdf_pkg::KSL);
         m3_fs_in[l] = f_full[sdf_pkg::FW-1:2*sdf_pkg::FRAC_BITS];
      end
   end

   // M4: b*|p| partial products
   sdf_pkg::tail_type                  m4_t_ff;
   logic                               m4_pneg_ff;
   logic [2:0][sdf_pkg::FSW-1:0]       m4_fs_ff;
   logic [sdf_pkg::KW+sdf_pkg::PML-1:0] m4_bl_ff, m4_bl_in;
   logic [sdf_pkg::KW+sdf_pkg::PMH-1:0] m4_bh_ff, m4_bh_in;

   always_comb begin
      m4_bl_in = (sdf_pkg::KW+sdf_pkg::PML)'(cfg.damping_coefficient) *
                 (sdf_pkg::KW+sdf_pkg::PML)'(m3_pm_ff[sdf_pkg::PML-1:0]);
      m4_bh_in = (sdf_pkg::KW+sdf_pkg::PMH)'(cfg.damping_coefficient) *
                 (sdf_pkg::KW+sdf_pkg::PMH)'(m3_pm_ff[sdf_pkg::PW-1:sdf_pkg::PML]);
   end

   // M5: b*|p|
   sdf_pkg::tail_type                  m5_t_ff;
   logic                               m5_pneg_ff;
   logic [2:0][sdf_pkg::FSW-1:0]       m5_fs_ff;
   logic [sdf_pkg::BPW-1:0]            m5_bp_ff, m5_bp_in;

   assign m5_bp_in = sdf_pkg::BPW'(m4_bl_ff) + (sdf_pkg::BPW'(m4_bh_ff) << sdf_pkg::PML);

   // M6: damping partial products per lane
   sdf_pkg::tail_type                           m6_t_ff;
   logic                                        m6_pneg_ff;
   logic [2:0][sdf_pkg::FSW-1:0]                m6_fs_ff;
   logic [2:0][sdf_pkg::BC+sdf_pkg::QW-1:0]     m6_c0_ff, m6_c0_in;
   logic [2:0][sdf_pkg::BC+sdf_pkg::QW-1:0]     m6_c1_ff, m6_c1_in;
   logic [2:0][sdf_pkg::BCT+sdf_pkg::QW-1:0]    m6_c2_ff, m6_c2_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         m6_c0_in[l] = (sdf_pkg::BC+sdf_pkg::QW)'(m5_bp_ff[sdf_pkg::BC-1:0]) *
                       (sdf_pkg::BC+sdf_pkg::QW)'(m5_t_ff.um[l]);
         m6_c1_in[l] = (sdf_pkg::BC+sdf_pkg::QW)'(m5_bp_ff[2*sdf_pkg::BC-1:sdf_pkg::BC]) *
                       (sdf_pkg::BC+sdf_pkg::QW)'(m5_t_ff.um[l]);
         m6_c2_in[l] = (sdf_pkg::BCT+sdf_pkg::QW)'(m5_bp_ff[sdf_pkg::BPW-1:2*sdf_pkg::BC]) *
                       (sdf_pkg::BCT+sdf_pkg::QW)'(m5_t_ff.um[l]);
      end
   end

   // M7: damping magnitude
   sdf_pkg::tail_type                  m7_t_ff;
   logic                               m7_pneg_ff;
   logic [2:0][sdf_pkg::FSW-1:0]       m7_fs_ff;
   logic [2:0][sdf_pkg::GSW-1:0]       m7_gs_ff, m7_gs_in;
   logic [sdf_pkg::GW-1:0]             g_full;

   always_comb begin
      g_full = '0;
      for (int l = 0; l < 3; l++) begin
         g_full = sdf_pkg::GW'(m6_c0_ff[l]) + (sdf_pkg::GW'(m6_c1_ff[l]) << sdf_pkg::BC) +
                  (sdf_pkg::GW'(m6_c2_ff[l]) << (2 * sdf_pkg::BC));
         m7_gs_in[l] = g_full[sdf_pkg::GW-1:3*sdf_pkg::FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_t_ff.valid <= 1'b0;
         m2_t_ff.valid <= 1'b0;
         m3_t_ff.valid <= 1'b0;
         m4_t_ff.valid <= 1'b0;
         m5_t_ff.valid <= 1'b0;
         m6_t_ff.valid <= 1'b0;
         m7_t_ff.valid <= 1'b0;
      end else if (en) begin
         m1_t_ff <= m1_t_in;
         m2_t_ff <= m1_t_ff;
         m3_t_ff <= m2_t_ff;
         m4_t_ff <= m3_t_ff;
         m5_t_ff <= m4_t_ff;
         m6_t_ff <= m5_t_ff;
         m7_t_ff <= m6_t_ff;
      end
      if (en) begin
         m1_prod_ff <= m1_prod_in;
         m1_ks_ff <= m1_ks_in;
         m2_p_ff <= m2_p_in;
         m2_fl_ff <= m2_fl_in;
         m2_fh_ff <= m2_fh_in;
         m3_pneg_ff <= m3_pneg_in;
         m3_pm_ff <= m3_pm_in;
         m3_fs_ff <= m3_fs_in;
         m4_pneg_ff <= m3_pneg_ff;
         m4_fs_ff <= m3_fs_ff;
         m4_bl_ff <= m4_bl_in;
         m4_bh_ff <= m4_bh_in;
         m5_pneg_ff <= m4_pneg_ff;
         m5_fs_ff <= m4_fs_ff;
         m5_bp_ff <= m5_bp_in;
         m6_pneg_ff <= m5_pneg_ff;
         m6_fs_ff <= m5_fs_ff;
         m6_c0_ff <= m6_c0_in;
         m6_c1_ff <= m6_c1_in;
         m6_c2_ff <= m6_c2_in;
         m7_pneg_ff <= m6_pneg_ff;
         m7_fs_ff <= m6_fs_ff;
         m7_gs_ff <= m7_gs_in;
      end
   end

   // saturation and signs
   logic [2:0][sdf_pkg::XW-1:0] fo;
   logic [2:0][sdf_pkg::XW-1:0] go;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         fo[l] = sat_out(sdf_pkg::SATW'(m7_fs_ff[l]), !m7_t_ff.neg[l]);
         go[l] = sat_out(sdf_pkg::SATW'(m7_gs_ff[l]), m7_pneg_ff == m7_t_ff.neg[l]);
      end
      out_data = '0;
      if (m7_t_ff.stretched) begin
         out_data.spring_fx = fo[0];
         out_data.spring_fy = fo[1];
         out_data.spring_fz = fo[2];
         out_data.damp_a_x = go[0];
         out_data.damp_a_y = go[1];
         out_data.damp_a_z = go[2];
         out_data.damp_b_x = go[0];
         out_data.damp_b_y = go[1];
         out_data.damp_b_z = go[2];
         out_data.stretched = 1'b1;
      end
   end

   assign out_valid = m7_t_ff.valid;

endmodule

/* hdl/spring_damper_force.sv */
// One-sided 3D spring-damper force evaluator, Q16.16 throughout.
// req channel: positions of both ends and their velocities, one transfer per
// spring evaluation; items are independent, so a new transfer may follow every
// cycle while req_stall is low. rsp channel: proxy-end spring force, damping
// increments for both ends, the stretched flag; all zero when not stretched.
// Registers (APB, 4-byte spaced): spring constant, rest length, damping
// coefficient. Write them only while no transfer is in flight.
// Throughput: one item per cycle while req_stall is low. Each result passes
// through the 34-stage square root, the 17-stage divider for the unit
// direction and seven multiply/add stages after it.
// A stalled rsp holds its payload; one more result lands in a skid register,
// then req_stall rises and the whole pipeline freezes until rsp drains.
// Reset (synchronous) empties the pipeline and the output registers and loads
// k = 1.0, L = 0, b = 0.
module spring_damper_force_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sdf_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sdf_pkg::rsp_type          rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [sdf_pkg::AW-1:0]    paddr,
   input  logic [sdf_pkg::PDW-1:0]   pwdata,
   output logic [sdf_pkg::PDW-1:0]   prdata,
   output logic                      pready
);

   sdf_pkg::cfg_type cfg_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spring_constant <= sdf_pkg::SPRING_CONSTANT_RESET;
         cfg_ff.rest_length <= '0;
         cfg_ff.damping_coefficient <= '0;
      end else if (psel && penable && pwrite) begin
         case (paddr[sdf_pkg::AW-1:2])
            sdf_pkg::REG_SPRING_CONSTANT:
               cfg_ff.spring_constant <= pwdata[sdf_pkg::KW-1:0];
            sdf_pkg::REG_REST_LENGTH:
               cfg_ff.rest_length <= pwdata[sdf_pkg::LW-1:0];
            sdf_pkg::REG_DAMPING_COEFFICIENT:
               cfg_ff.damping_coefficient <= pwdata[sdf_pkg::KW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[sdf_pkg::AW-1:2])
         sdf_pkg::REG_SPRING_CONSTANT:     prdata = sdf_pkg::PDW'(cfg_ff.spring_constant);
         sdf_pkg::REG_REST_LENGTH:         prdata = sdf_pkg::PDW'(cfg_ff.rest_length);
         sdf_pkg::REG_DAMPING_COEFFICIENT: prdata = sdf_pkg::PDW'(cfg_ff.damping_coefficient);
         default:                          prdata = '0;
      endcase
   end

   logic             en;
   logic             dp_valid;
   sdf_pkg::rsp_type dp_data;
   logic             arr;
   logic             take;

   logic             out_v_ff, out_v_in;
   sdf_pkg::rsp_type out_ff, out_in;
   logic             skid_v_ff, skid_v_in;
   sdf_pkg::rsp_type skid_ff, skid_in;

   assign en = !skid_v_ff;
   assign req_stall = skid_v_ff;

   sdf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (dp_valid),
      .out_data  (dp_data)
   );

   assign arr = dp_valid && en;
   assign take = out_v_ff && !rsp_stall;

   always_comb begin
      out_v_in = out_v_ff;
      out_in = out_ff;
      skid_v_in = skid_v_ff;
      skid_in = skid_ff;
      if (!out_v_ff || take) begin
         if (skid_v_ff) begin
            out_v_in = 1'b1;
            out_in = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = arr;
            out_in = dp_data;
         end
      end else if (arr) begin
         skid_v_in = 1'b1;
         skid_in = dp_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a result while output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && rsp_stall |=> skid_v_ff)
      else $error("skid result lost during stall");

   a_slack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.stretched |->
         rsp_data.spring_fx == 0 && rsp_data.spring_fy == 0 && rsp_data.spring_fz == 0 &&
         rsp_data.damp_a_x == 0 && rsp_data.damp_a_y == 0 && rsp_data.damp_a_z == 0)
      else $error("nonzero force while not stretched");

   a_damp_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.damp_b_x == rsp_data.damp_a_x &&
                    rsp_data.damp_b_y == rsp_data.damp_a_y &&
                    rsp_data.damp_b_z == rsp_data.damp_a_z)
      else $error("damping increments of both ends differ");

endmodule
